### hdl/aewu_pkg.sv
// Shared types and constants for the ADC event word unpacker.
package aewu_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned STAMP_W    = 48;
    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned CRATE_W    = 7;
    localparam int unsigned CHAN_W     = 5;
    localparam int unsigned AMP_W      = 12;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned M_TDATA_W  = 120;

    // word bit positions
    localparam int unsigned TRAILER_BIT = 10;
    localparam int unsigned UNDER_BIT   = 13;
    localparam int unsigned OVER_BIT    = 12;

    // result bit positions in m_tdata
    localparam int unsigned OFS_STAMP  = 0;
    localparam int unsigned OFS_SLOT   = 48;
    localparam int unsigned OFS_CRATE  = 53;
    localparam int unsigned OFS_CHAN   = 60;
    localparam int unsigned OFS_AMP    = 65;
    localparam int unsigned OFS_UNDER  = 77;
    localparam int unsigned OFS_OVER   = 78;
    localparam int unsigned OFS_HITS   = 79;
    localparam int unsigned OFS_STATUS = 85;
    localparam int unsigned OFS_TOTAL  = 87;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRAILER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_EOB  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

    localparam logic KIND_HIT     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        PH_SIZE  = 4'd0,
        PH_CLK1  = 4'd1,
        PH_CLK2  = 4'd2,
        PH_CLK3  = 4'd3,
        PH_CLK4  = 4'd4,
        PH_CLK5  = 4'd5,
        PH_CLK6  = 4'd6,
        PH_HDR_A = 4'd7,
        PH_HDR_B = 4'd8,
        PH_DAT_A = 4'd9,
        PH_DAT_B = 4'd10,
        PH_EOB_A = 4'd11,
        PH_EOB_B = 4'd12
    } aewu_phase_t;

    typedef struct packed {
        logic                kind;
        logic [STAMP_W-1:0]  timestamp;
        logic [SLOT_W-1:0]   slot;
        logic [CRATE_W-1:0]  crate_id;
        logic [CHAN_W-1:0]   chan;
        logic [AMP_W-1:0]    amplitude;
        logic                under_flag;
        logic                over_flag;
        logic [COUNT_W-1:0]  hits_in_event;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  hit_total;
        logic                last;
    } aewu_result_t;

endpackage

### hdl/aewu_parse.sv
// Word parser: event phase sequencer, event fields and hit counters.
module aewu_parse
    import aewu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [WORD_W-1:0]    word,
    output logic                 res_valid,
    output aewu_result_t         res
);

    aewu_phase_t         phase_reg, phase_next;
    logic [WORD_W-1:0]   held_word_reg, held_word_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CRATE_W-1:0]  crate_reg, crate_next;
    logic [COUNT_W-1:0]  expected_reg, expected_next;
    logic [COUNT_W-1:0]  seen_reg, seen_next;
    logic [COUNT_W-1:0]  hit_count_reg, hit_count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0]  seen_inc;
    logic                trailer;

    assign seen_inc = seen_reg + COUNT_W'(1);
    assign trailer  = word[TRAILER_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            held_word_reg <= '0;
            stamp_reg     <= '0;
            slot_reg      <= '0;
            crate_reg     <= '0;
            expected_reg  <= '0;
            seen_reg      <= '0;
            hit_count_reg <= '0;
            total_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            held_word_reg <= held_word_next;
            stamp_reg     <= stamp_next;
            slot_reg      <= slot_next;
            crate_reg     <= crate_next;
            expected_reg  <= expected_next;
            seen_reg      <= seen_next;
            hit_count_reg <= hit_count_next;
            total_reg     <= total_next;
        end
    end

    always_comb
    begin
        phase_next = PH_SIZE;
        unique case (phase_reg)
            PH_SIZE:  phase_next = PH_CLK1;
            PH_CLK1:  phase_next = PH_CLK2;
            PH_CLK2:  phase_next = PH_CLK3;
            PH_CLK3:  phase_next = PH_CLK4;
            PH_CLK4:  phase_next = PH_CLK5;
            PH_CLK5:  phase_next = PH_CLK6;
            PH_CLK6:  phase_next = PH_HDR_A;
            PH_HDR_A: phase_next = PH_HDR_B;
            PH_HDR_B: phase_next = (held_word_reg[13:8] != '0) ? PH_DAT_A : PH_EOB_A;
            PH_DAT_A: phase_next = PH_DAT_B;
            PH_DAT_B:
            begin
                if (trailer)
                    phase_next = PH_SIZE;
                else
                    phase_next = (seen_inc == expected_reg) ? PH_EOB_A : PH_DAT_A;
            end
            PH_EOB_A: phase_next = PH_EOB_B;
            PH_EOB_B: phase_next = PH_SIZE;
            default:  phase_next = PH_CLK1;
        endcase
    end

    always_comb
    begin
        held_word_next = held_word_reg;
        stamp_next     = stamp_reg;
        slot_next      = slot_reg;
        crate_next     = crate_reg;
        expected_next  = expected_reg;
        seen_next      = seen_reg;
        hit_count_next = hit_count_reg;
        total_next     = total_reg;
        res_valid      = 1'b0;
        res.kind       = KIND_SUMMARY;
        res.chan       = '0;
        res.amplitude  = '0;
        res.under_flag = 1'b0;
        res.over_flag  = 1'b0;
        res.status     = ST_OK;
        res.last       = 1'b1;
        unique case (phase_reg)
            PH_CLK3: stamp_next = {32'd0, word};
            PH_CLK4: stamp_next = {16'd0, word, stamp_reg[15:0]};
            PH_CLK6: stamp_next = {word, stamp_reg[31:0]};
            PH_HDR_A, PH_DAT_A, PH_EOB_A: held_word_next = word;
            PH_HDR_B:
            begin
                slot_next      = word[15:11];
                crate_next     = word[9:3];
                expected_next  = held_word_reg[13:8];
                seen_next      = '0;
                hit_count_next = '0;
            end
            PH_DAT_B:
            begin
                res_valid = 1'b1;
                if (trailer)
                begin
                    res.status = ST_TRAILER;
                end
                else
                begin
                    hit_count_next = hit_count_reg + COUNT_W'(1);
                    total_next     = total_reg + TOTAL_W'(1);
                    seen_next      = seen_inc;
                    res.kind       = KIND_HIT;
                    res.chan       = word[CHAN_W-1:0];
                    res.amplitude  = held_word_reg[AMP_W-1:0];
                    res.under_flag = held_word_reg[UNDER_BIT];
                    res.over_flag  = held_word_reg[OVER_BIT];
                    res.last       = 1'b0;
                end
            end
            PH_EOB_B:
            begin
                res_valid  = 1'b1;
                res.status = trailer ? ST_OK : ST_NO_EOB;
            end
            default:
            begin
                held_word_next = held_word_reg;
            end
        endcase
        res.timestamp     = stamp_next;
        res.slot          = slot_next;
        res.crate_id      = crate_next;
        res.hits_in_event = hit_count_next;
        res.hit_total     = total_next;
    end

endmodule

### hdl/adc_event_word_unpacker.sv
// Top level of the ADC event word unpacker: parser and result register.
//
//   channel | dir | payload
//   s_*     | in  | tdata[15:0] word
//   m_*     | out | tdata hit or summary fields, tuser kind, tlast closes the event
//
// One word per cycle while s_tready is high; each request is parsed in the cycle it is accepted and
// its result, if any, sits in the output register on the next cycle.
// s_tready is high while the output register is empty or being drained.
// Reset returns the parser to the size-word phase and clears all counters.
// A stall on m_tready holds the result and stops input only while it persists.
module adc_event_word_unpacker
    import aewu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,  // word[15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // timestamp[47:0] slot[52:48] crate_id[59:53]
                                            // chan[64:60] amplitude[76:65] under_flag[77]
                                            // over_flag[78] hits_in_event[84:79]
                                            // status[86:85] hit_total[118:87] zero[119]
    output logic [0:0]            m_tuser,  // kind[0]
    output logic                  m_tlast
);

    logic         take;
    logic         res_valid;
    aewu_result_t res;
    logic         out_valid_reg;
    aewu_result_t out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    aewu_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .word      (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            out_reg <= res;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_reg.kind;
    assign m_tlast    = out_reg.last;
    assign m_tdata    = {1'b0, out_reg.hit_total, out_reg.status, out_reg.hits_in_event,
                         out_reg.over_flag, out_reg.under_flag, out_reg.amplitude,
                         out_reg.chan, out_reg.crate_id, out_reg.slot, out_reg.timestamp};

endmodule

### hdl/aewu_checker.sv
// Port-level checks for the ADC event word unpacker and their binding.
module aewu_checker
    import aewu_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 m_tlast
);

    logic [STATUS_W-1:0] status;
    logic                summary_clear;

    assign status        = m_tdata[OFS_STATUS +: STATUS_W];
    assign summary_clear = (m_tdata[OFS_CHAN +: CHAN_W] == '0)
                        && (m_tdata[OFS_AMP +: AMP_W] == '0)
                        && !m_tdata[OFS_UNDER] && !m_tdata[OFS_OVER];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_hit_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == KIND_HIT) |-> !m_tlast && (status == ST_OK))
        else $error("hit carries summary marks");

    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == KIND_SUMMARY) |-> m_tlast && summary_clear)
        else $error("summary carries hit fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status != ST_BAD) && !m_tdata[M_TDATA_W-1])
        else $error("bad status code or pad bit");

endmodule

bind adc_event_word_unpacker aewu_checker u_aewu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### bench/testbench.sv
// Self-checking testbench for the ADC event word unpacker stream block.
`timescale 1ns / 100ps

module testbench;
    import aewu_pkg::*;

    localparam int WORD_GOAL = 800;
    localparam int RUN_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;   // word[15:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // timestamp slot crate_id chan amplitude under_flag
                                     // over_flag hits_in_event status hit_total zero
    logic [0:0]           m_tuser;   // kind
    logic                 m_tlast;

    class event_scoreboard;
        aewu_phase_t        phase;
        logic [WORD_W-1:0]  held_word;
        logic [STAMP_W-1:0] stamp;
        logic [SLOT_W-1:0]  slot_reg;
        logic [CRATE_W-1:0] crate_reg;
        logic [COUNT_W-1:0] expected_pairs;
        logic [COUNT_W-1:0] pairs_seen;
        logic [COUNT_W-1:0] hit_count;
        logic [TOTAL_W-1:0] total_hits;
        aewu_result_t       pending_results[$];
        int                 mismatches;
        int                 results_seen;
        int                 hits_seen;
        int                 summaries_seen[4];

        function new();
            phase = PH_SIZE;
            held_word = '0;
            stamp = '0;
            slot_reg = '0;
            crate_reg = '0;
            expected_pairs = '0;
            pairs_seen = '0;
            hit_count = '0;
            total_hits = '0;
            mismatches = 0;
            results_seen = 0;
            hits_seen = 0;
            summaries_seen = '{0, 0, 0, 0};
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void queue_result(logic kind, logic [CHAN_W-1:0] chan,
                                   logic [AMP_W-1:0] amp, logic uf, logic of,
                                   logic [STATUS_W-1:0] status, logic last);
            aewu_result_t r;
            r.kind = kind;
            r.timestamp = stamp;
            r.slot = slot_reg;
            r.crate_id = crate_reg;
            r.chan = chan;
            r.amplitude = amp;
            r.under_flag = uf;
            r.over_flag = of;
            r.hits_in_event = hit_count;
            r.status = status;
            r.hit_total = total_hits;
            r.last = last;
            pending_results.push_back(r);
        endfunction

        function void predict_word(logic [WORD_W-1:0] w);
            case (phase)
                PH_CLK1, PH_CLK2, PH_CLK5:
                    phase = aewu_phase_t'(phase + 4'd1);
                PH_CLK3:
                begin
                    stamp = {32'd0, w};
                    phase = PH_CLK4;
                end
                PH_CLK4:
                begin
                    stamp = {16'd0, w, stamp[15:0]};
                    phase = PH_CLK5;
                end
                PH_CLK6:
                begin
                    stamp = {w, stamp[31:0]};
                    phase = PH_HDR_A;
                end
                PH_HDR_A, PH_DAT_A, PH_EOB_A:
                begin
                    held_word = w;
                    phase = aewu_phase_t'(phase + 4'd1);
                end
                PH_HDR_B:
                begin
                    slot_reg = w[15:11];
                    crate_reg = w[9:3];
                    expected_pairs = held_word[13:8];
                    pairs_seen = '0;
                    hit_count = '0;
                    phase = (expected_pairs != 0) ? PH_DAT_A : PH_EOB_A;
                end
                PH_DAT_B:
                begin
                    if (w[TRAILER_BIT])
                    begin
                        queue_result(KIND_SUMMARY, '0, '0, 1'b0, 1'b0, ST_TRAILER, 1'b1);
                        phase = PH_SIZE;
                    end
                    else
                    begin
                        hit_count = hit_count + 1'b1;
                        total_hits = total_hits + 1'b1;
                        pairs_seen = pairs_seen + 1'b1;
                        queue_result(KIND_HIT, w[4:0], held_word[11:0],
                                     held_word[UNDER_BIT], held_word[OVER_BIT], ST_OK, 1'b0);
                        phase = (pairs_seen == expected_pairs) ? PH_EOB_A : PH_DAT_A;
                    end
                end
                PH_EOB_B:
                begin
                    queue_result(KIND_SUMMARY, '0, '0, 1'b0, 1'b0,
                                 w[TRAILER_BIT] ? ST_OK : ST_NO_EOB, 1'b1);
                    phase = PH_SIZE;
                end
                default:
                    phase = PH_CLK1;
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d, %s: expected %0h, got %0h",
                             results_seen, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [0:0] user,
                                   logic tlast);
            aewu_result_t e;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: tdata %0h, tuser %0h, tlast %0b",
                             results_seen, data, user, tlast);
                return;
            end
            e = pending_results.pop_front();
            if (e.kind == KIND_HIT)
                hits_seen++;
            else
                summaries_seen[e.status]++;
            compare_field("kind", e.kind, user[0]);
            compare_field("timestamp", e.timestamp, data[OFS_STAMP +: STAMP_W]);
            compare_field("slot", e.slot, data[OFS_SLOT +: SLOT_W]);
            compare_field("crate_id", e.crate_id, data[OFS_CRATE +: CRATE_W]);
            compare_field("chan", e.chan, data[OFS_CHAN +: CHAN_W]);
            compare_field("amplitude", e.amplitude, data[OFS_AMP +: AMP_W]);
            compare_field("under_flag", e.under_flag, data[OFS_UNDER]);
            compare_field("over_flag", e.over_flag, data[OFS_OVER]);
            compare_field("hits_in_event", e.hits_in_event, data[OFS_HITS +: COUNT_W]);
            compare_field("status", e.status, data[OFS_STATUS +: STATUS_W]);
            compare_field("hit_total", e.hit_total, data[OFS_TOTAL +: TOTAL_W]);
            compare_field("last", e.last, tlast);
        endfunction
    endclass

    event_scoreboard sb;
    int cycles;
    int words_sent;
    int noise_bursts;
    logic [WORD_W-1:0] directed_words [24];

    adc_event_word_unpacker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_word(input logic [WORD_W-1:0] w);
        bit steady;
        steady = (words_sent >= 300 && words_sent < 450);
        while (!steady && $urandom_range(99) < 21)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = w;
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_event(input int n_hits, input int trailer_at, input bit eob_set);
        logic [WORD_W-1:0] w;
        send_word(16'($urandom));
        repeat (6)
            send_word(16'($urandom));
        w = 16'($urandom);
        w[13:8] = 6'(n_hits);
        send_word(w);
        send_word(16'($urandom));
        for (int i = 0; i < n_hits; i++)
        begin
            send_word(16'($urandom));
            w = 16'($urandom);
            w[TRAILER_BIT] = (i == trailer_at);
            send_word(w);
            if (i == trailer_at)
                return;
        end
        send_word(16'($urandom));
        w = 16'($urandom);
        w[TRAILER_BIT] = eob_set;
        send_word(w);
    endtask

    initial
    begin
        bit pressure_done;
        int hold_left;
        pressure_done = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (!pressure_done && sb != null && sb.results_seen >= 60)
            begin
                pressure_done = 1;
                hold_left = 150;
                m_tready = 1'b0;
            end
            else if (cycles >= 1500 && cycles < 2500)
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(99) >= 21);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int n_hits;
        int trailer_at;
        bit eob_set;
        sb = new();
        words_sent = 0;
        noise_bursts = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        directed_words = '{
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hC0FF, 16'hFFFF, 16'hFFFF, 16'hFBFF,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0200, 16'h0000, 16'h3FFF, 16'h001F, 16'h0000, 16'h0400
        };
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_words[i])
            send_word(directed_words[i]);

        while (words_sent < WORD_GOAL)
        begin
            if ($urandom_range(99) < 87)
            begin
                if ($urandom_range(19) == 0)
                    n_hits = 63;
                else if ($urandom_range(9) == 0)
                    n_hits = $urandom_range(63);
                else
                    n_hits = $urandom_range(6);
                trailer_at = -1;
                if (n_hits > 0 && $urandom_range(99) < 15)
                    trailer_at = $urandom_range(n_hits - 1);
                eob_set = ($urandom_range(99) < 85);
                send_event(n_hits, trailer_at, eob_set);
            end
            else
            begin
                noise_bursts++;
                repeat ($urandom_range(1, 20))
                    send_word(16'($urandom));
                while (sb.phase != PH_SIZE)
                    send_word(16'($urandom));
            end
        end
        s_tvalid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.mismatches++;

        $display("sent %0d words including %0d noise bursts; checked %0d results",
                 words_sent, noise_bursts, sb.results_seen);
        $display("hits %0d, event ends ok %0d, early trailer %0d, missing end-of-block %0d",
                 sb.hits_seen, sb.summaries_seen[ST_OK], sb.summaries_seen[ST_TRAILER],
                 sb.summaries_seen[ST_NO_EOB]);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
